[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled while the asynchronous reset is low
`define CHK_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define CHK_NEVER(name, clk, rst_n, expr, msg) \
	`CHK_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

[rtl/mlpf_pkg.sv]
// ----------------------------------------------------------------------------
// mlpf_pkg
// Shared types, constants and arithmetic helpers of the 2-3-1 perceptron
// fitness evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlpf_pkg;

	localparam int ROW_COUNT_DEF   = 256;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam int ERR_W      = 48;
	localparam int RECIP_W    = 33;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 48;
	localparam int MUL_X_W    = 33;
	localparam int MUL_Y_W    = 17;
	localparam int MUL_W      = MUL_X_W + MUL_Y_W;
	localparam int PROD_W     = 48;
	localparam int PART_W     = 32;
	localparam int H_W        = 32;
	localparam int Z_W        = 49;
	localparam int Q16_W      = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WB = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WO = 2'd2;

	localparam logic [Q16_W-1:0] Q16_MAX = 16'hFFFF;

	// segment knees of the piecewise-linear sigmoid, magnitude in Q12.36
	localparam logic [Z_W-1:0] SIG_MAG_SAT = Z_W'(64'd5 << 36);
	localparam logic [Z_W-1:0] SIG_MAG_MID = Z_W'(64'd19 << 33);
	localparam logic [Z_W-1:0] SIG_MAG_ONE = Z_W'(64'd1 << 36);
	localparam logic [16:0] SIG_ONE     = 17'd65536;
	localparam logic [16:0] SIG_OFS_HI  = 17'd55296;
	localparam logic [16:0] SIG_OFS_MID = 17'd40960;
	localparam logic [16:0] SIG_OFS_LO  = 17'd32768;

	typedef struct packed {
		logic signed [15:0] feature_a;
		logic signed [15:0] feature_b;
		logic               label;
		logic               last_sample;
	} in_item_t;

	typedef struct packed {
		logic [15:0] prediction;
		logic [15:0] mean_loss;
		logic        last_out;
	} out_item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] wa;
		logic [CFG_DATA_W-1:0] wb;
		logic [CFG_DATA_W-1:0] wo;
	} weights_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HA,
		ST_HB,
		ST_HSUM,
		ST_OUT,
		ST_ZFIN,
		ST_SIG,
		ST_SQ,
		ST_ACC,
		ST_DIV,
		ST_EMIT
	} back_state_t;

	// signed Q4.12 weight of unit j from a packed register
	function automatic logic signed [15:0] unit_weight(input logic [CFG_DATA_W-1:0] r,
		input logic [1:0] j);
		logic signed [15:0] w;
		case (j)
			2'd0: w = r[15:0];
			2'd1: w = r[31:16];
			2'd2: w = r[47:32];
			default: w = '0;
		endcase
		return w;
	endfunction

	// piecewise-linear sigmoid, Q12.36 in, Q0.16 out, saturated
	function automatic logic [Q16_W-1:0] sigmoid_q16(input logic signed [Z_W-1:0] z);
		logic [Z_W-1:0] mag;
		logic [16:0]    s;
		logic [16:0]    r;
		mag = z[Z_W-1] ? Z_W'(-z) : Z_W'(z);
		if (mag >= SIG_MAG_SAT) begin
			s = SIG_ONE;
		end else if (mag >= SIG_MAG_MID) begin
			s = 17'(mag >> 25) + SIG_OFS_HI;
		end else if (mag >= SIG_MAG_ONE) begin
			s = 17'(mag >> 23) + SIG_OFS_MID;
		end else begin
			s = 17'(mag >> 22) + SIG_OFS_LO;
		end
		r = z[Z_W-1] ? (SIG_ONE - s) : s;
		return r[16] ? Q16_MAX : r[Q16_W-1:0];
	endfunction

endpackage

[rtl/mlpf_div.sv]
// ----------------------------------------------------------------------------
// mlpf_div
// Mean of the error sum: drops the low 16 fraction bits, divides by the row
// count with a rounded-up reciprocal multiply, registering the numerator and
// then the product, and saturates the quotient to Q0.16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlpf_div import mlpf_pkg::*; #(
	parameter int DIVISOR = ROW_COUNT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ERR_W-1:0] dividend,
	output logic             done,
	output logic [Q16_W-1:0] mean
);

	localparam int NUM_W    = ERR_W - Q16_W;
	localparam int RECIP_SH = NUM_W + $clog2(DIVISOR);
	localparam int PROD2_W  = NUM_W + RECIP_W;
	// ceil(2^RECIP_SH / DIVISOR) is exact for every numerator below 2^NUM_W
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	logic               num_v_s1;
	logic               prod_v_s2;
	logic [NUM_W-1:0]   num_s1;
	logic [PROD2_W-1:0] prod_s2;
	logic [NUM_W-1:0]   quo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_v_s1  <= 1'b0;
			prod_v_s2 <= 1'b0;
		end else begin
			num_v_s1  <= start;
			prod_v_s2 <= num_v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_s1 <= dividend[ERR_W-1:Q16_W];
		end
		if (num_v_s1) begin
			prod_s2 <= num_s1 * RECIP;
		end
	end

	assign quo  = NUM_W'(prod_s2 >> RECIP_SH);
	assign done = prod_v_s2;
	assign mean = (quo[NUM_W-1:Q16_W] != '0) ? Q16_MAX : quo[Q16_W-1:0];

endmodule

[rtl/mlpf_front.sv]
// ----------------------------------------------------------------------------
// mlpf_front
// Sample intake: weight registers, input handshake and the sample queue
// that feeds the arithmetic sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlpf_front import mlpf_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  in_item_t              sample,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output weights_t              weights,
	output logic                  q_valid,
	output in_item_t              q_item,
	input  logic                  q_pop
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	weights_t         weights_q;
	in_item_t         fifo_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weights_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_WA: weights_q.wa <= cfg_data;
				CFG_IDX_WB: weights_q.wb <= cfg_data;
				CFG_IDX_WO: weights_q.wo <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sample_stall = (count_q == CNT_FULL);
	assign push         = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= sample;
		end
	end

	assign weights = weights_q;
	assign q_valid = (count_q != '0);
	assign q_item  = fifo_q[rd_ptr_q];

	`CHK_ASSERT(a_count_bound, clk, arst_n, count_q <= CNT_FULL, "queue count past depth")
	`CHK_NEVER(a_pop_empty, clk, arst_n, q_pop && (count_q == '0), "queue popped while empty")

endmodule

[rtl/mlpf_back.sv]
// ----------------------------------------------------------------------------
// mlpf_back
// Arithmetic sequencer: hidden and output layers, sigmoid, squared error and its
// accumulation (their products share one multiplier), mean divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mlpf_back import mlpf_pkg::*; #(
	parameter int ROW_COUNT = ROW_COUNT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  weights_t  weights,
	input  logic      q_valid,
	input  in_item_t  q_item,
	output logic      q_pop,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	back_state_t state_q;
	back_state_t state_d;

	logic [1:0]               j_q;
	in_item_t                 item_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PART_W-1:0] part_q;
	logic [H_W-1:0]           h_q;
	logic signed [Z_W-1:0]    z_q;
	logic [Q16_W-1:0]         p_q;
	logic [Q16_W-1:0]         mean_q;
	logic [ERR_W-1:0]         error_sum_q;
	logic                     result_valid_q;
	out_item_t                result_q;

	logic signed [MUL_X_W-1:0] op_x;
	logic signed [MUL_Y_W-1:0] op_y;
	logic signed [MUL_W-1:0]   mult_full;
	logic signed [H_W:0]       hsum;
	logic [H_W-1:0]            h_d;
	logic signed [16:0]        diff;
	logic [ERR_W:0]            sum_ext;
	logic [ERR_W-1:0]          sum_sat;
	logic                      div_start;
	logic                      div_done;
	logic [Q16_W-1:0]          div_mean;
	logic                      out_free;

	assign q_pop    = (state_q == ST_IDLE) && q_valid;
	assign out_free = !result_valid_q || !result_stall;

	// p - 65536 for label 1 is p with a sign bit on top
	assign diff = {item_q.label, p_q};

	always_comb begin
		op_x = '0;
		op_y = '0;
		case (state_q)
			ST_HA: begin
				op_x = MUL_X_W'(item_q.feature_a);
				op_y = MUL_Y_W'(unit_weight(weights.wa, j_q));
			end
			ST_HB: begin
				op_x = MUL_X_W'(item_q.feature_b);
				op_y = MUL_Y_W'(unit_weight(weights.wb, j_q));
			end
			ST_OUT: begin
				op_x = {1'b0, h_q};
				op_y = MUL_Y_W'(unit_weight(weights.wo, j_q));
			end
			ST_SQ: begin
				op_x = MUL_X_W'(diff);
				op_y = diff;
			end
			default: ;
		endcase
	end

	assign mult_full = op_x * op_y;

	assign hsum    = (H_W + 1)'(part_q) + (H_W + 1)'($signed(prod_q[PART_W-1:0]));
	assign h_d     = hsum[H_W] ? '0 : hsum[H_W-1:0];
	assign sum_ext = {1'b0, error_sum_q} + (ERR_W + 1)'(prod_q[32:0]);
	assign sum_sat = sum_ext[ERR_W] ? '1 : sum_ext[ERR_W-1:0];

	assign div_start = (state_q == ST_ACC) && item_q.last_sample;

	mlpf_div #(
		.DIVISOR (ROW_COUNT)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_sat),
		.done     (div_done),
		.mean     (div_mean)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (q_valid) state_d = ST_HA;
			ST_HA:   state_d = ST_HB;
			ST_HB:   state_d = ST_HSUM;
			ST_HSUM: state_d = ST_OUT;
			ST_OUT:  state_d = (j_q == 2'd2) ? ST_ZFIN : ST_HA;
			ST_ZFIN: state_d = ST_SIG;
			ST_SIG:  state_d = ST_SQ;
			ST_SQ:   state_d = ST_ACC;
			ST_ACC:  state_d = item_q.last_sample ? ST_DIV : ST_EMIT;
			ST_DIV:  if (div_done) state_d = ST_EMIT;
			ST_EMIT: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q            <= '0;
			error_sum_q    <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				j_q <= '0;
			end else if (state_q == ST_OUT) begin
				j_q <= j_q + 1'b1;
			end
			if (state_q == ST_ACC) begin
				error_sum_q <= item_q.last_sample ? '0 : sum_sat;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= q_item;
		end
		case (state_q)
			ST_HA: begin
				prod_q <= mult_full[PROD_W-1:0];
				// previous unit's output product joins z here
				z_q <= (j_q == 2'd0) ? '0 : z_q + Z_W'(prod_q);
			end
			ST_HB: begin
				part_q <= prod_q[PART_W-1:0];
				prod_q <= mult_full[PROD_W-1:0];
			end
			ST_HSUM: h_q <= h_d;
			ST_OUT:  prod_q <= mult_full[PROD_W-1:0];
			ST_ZFIN: z_q <= z_q + Z_W'(prod_q);
			ST_SIG:  p_q <= sigmoid_q16(z_q);
			ST_SQ:   prod_q <= mult_full[PROD_W-1:0];
			ST_ACC:  if (!item_q.last_sample) mean_q <= '0;
			ST_DIV:  if (div_done) mean_q <= div_mean;
			ST_EMIT: begin
				if (out_free) begin
					result_q.prediction <= p_q;
					result_q.mean_loss  <= mean_q;
					result_q.last_out   <= item_q.last_sample;
				end
			end
			default: ;
		endcase
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`CHK_ASSERT(a_result_from_emit, clk, arst_n, $rose(result_valid_q) |-> $past(state_q == ST_EMIT), "result raised outside emit")
	`CHK_ASSERT(a_sum_cleared, clk, arst_n, ((state_q == ST_ACC) && item_q.last_sample) |=> (error_sum_q == '0), "error sum not cleared on last sample")

endmodule

[rtl/mlp_2_3_1_fitness_top.sv]
// ----------------------------------------------------------------------------
// mlp_2_3_1_fitness_top: 2-3-1 perceptron mean-squared-error evaluator
// the sequencer takes a new sample only after emitting its last result, since
// ten products share one 33x17 multiplier in it; a last sample also waits for the
// mean divider's reciprocal multiply by 1/ROW_COUNT
// reset clears weights, sample queue and error sum at once, no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlp_2_3_1_fitness_top import mlpf_pkg::*; #(
	parameter int ROW_COUNT   = ROW_COUNT_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_stall,
	input  in_item_t              sample,
	output logic                  result_valid,
	input  logic                  result_stall,
	output out_item_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	weights_t weights;
	logic     q_valid;
	in_item_t q_item;
	logic     q_pop;

	mlpf_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.weights      (weights),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	mlpf_back #(
		.ROW_COUNT (ROW_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.weights      (weights),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

[verif/tb_mlp_2_3_1_fitness_top.sv]
// ----------------------------------------------------------------------------
// tb_mlp_2_3_1_fitness_top
// Self-checking bench for the 2-3-1 perceptron loss evaluator. A scoreboard
// runs the forward pass, sigmoid and error accumulation at bit level for each
// accepted sample and compares every result field against it. Stimulus is a
// directed set of sigmoid knees and extreme weights, random data sets under
// changing weights with random stalls on both sides, and a calm run of
// worst-case errors that drives the mean past its clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_mlp_2_3_1_fitness_top;
	import mlpf_pkg::*;

	localparam int ROWS_TB = ROW_COUNT_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
	localparam longint unsigned ERR_MAX = 64'hFFFF_FFFF_FFFF;

	class mlp_loss_board;
		logic [CFG_DATA_W-1:0] wa, wb, wo;
		longint unsigned err_acc;
		out_item_t outputs_due[$];
		int errors;
		int results_seen;

		function new();
			wa = '0;
			wb = '0;
			wo = '0;
			err_acc = 0;
			errors = 0;
			results_seen = 0;
		endfunction

		function void set_weights(logic [CFG_DATA_W-1:0] a_w, logic [CFG_DATA_W-1:0] b_w,
			logic [CFG_DATA_W-1:0] o_w);
			wa = a_w;
			wb = b_w;
			wo = o_w;
		endfunction

		// forward pass, piecewise sigmoid and squared error of one sample
		function void add_sample(in_item_t s);
			longint h, z, mag, shaped, diff;
			longint unsigned mean;
			out_item_t e;
			z = 0;
			for (int j = 0; j < 3; j++) begin
				h = longint'($signed(s.feature_a)) * longint'($signed(wa[16*j +: 16]))
					+ longint'($signed(s.feature_b)) * longint'($signed(wb[16*j +: 16]));
				if (h < 0)
					h = 0;
				z += h * longint'($signed(wo[16*j +: 16]));
			end
			mag = (z < 0) ? -z : z;
			if (mag >= (longint'(5) << 36)) begin
				shaped = 65536;
			end else if (mag >= (longint'(19) << 33)) begin
				shaped = (mag >>> 25) + 55296;
			end else if (mag >= (longint'(1) << 36)) begin
				shaped = (mag >>> 23) + 40960;
			end else begin
				shaped = (mag >>> 22) + 32768;
			end
			if (z < 0)
				shaped = 65536 - shaped;
			if (shaped > 65535)
				shaped = 65535;
			diff = shaped - (s.label ? 65536 : 0);
			err_acc = err_acc + longint'(diff * diff);
			if (err_acc > ERR_MAX)
				err_acc = ERR_MAX;
			mean = 0;
			if (s.last_sample) begin
				mean = (err_acc / ROWS_TB) >> 16;
				if (mean > 65535)
					mean = 65535;
				err_acc = 0;
			end
			e.prediction = 16'(shaped);
			e.mean_loss = 16'(mean);
			e.last_out = s.last_sample;
			outputs_due.push_back(e);
		endfunction

		function void check_output(out_item_t got);
			out_item_t want;
			results_seen++;
			if (outputs_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result pred=%h loss=%h last=%b",
						got.prediction, got.mean_loss, got.last_out);
			end else begin
				want = outputs_due.pop_front();
				if (got.prediction !== want.prediction || got.mean_loss !== want.mean_loss
					|| got.last_out !== want.last_out) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected pred=%h loss=%h last=%b, got pred=%h loss=%h last=%b",
							results_seen, want.prediction, want.mean_loss, want.last_out,
							got.prediction, got.mean_loss, got.last_out);
				end
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	in_item_t              sample;
	logic                  result_valid;
	logic                  result_stall;
	out_item_t             result;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	mlp_loss_board board;
	bit calm;

	mlp_2_3_1_fitness_top #(
		.ROW_COUNT(ROWS_TB)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20000000;
		$display("Test completed with failures");
		$finish;
	end

	// offer one sample, with an occasional gap, and wait for the transaction
	task automatic send_sample(input in_item_t s);
		if (!calm && $urandom_range(3) == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		board.add_sample(s);
	endtask

	// let every pending result come out so the block is idle
	task automatic settle();
		sample_valid <= 1'b0;
		while (board.outputs_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// writes all three registers plus one write to the unused index
	task automatic load_weights(input logic [CFG_DATA_W-1:0] a_w,
		input logic [CFG_DATA_W-1:0] b_w, input logic [CFG_DATA_W-1:0] o_w);
		cfg_we <= 1'b1;
		cfg_index <= CFG_IDX_WA;
		cfg_data <= a_w;
		@(posedge clk);
		cfg_index <= CFG_IDX_WB;
		cfg_data <= b_w;
		@(posedge clk);
		cfg_index <= CFG_IDX_WO;
		cfg_data <= o_w;
		@(posedge clk);
		cfg_index <= CFG_IDX_SPARE;
		cfg_data <= CFG_DATA_W'({$urandom, $urandom});
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_weights(a_w, b_w, o_w);
	endtask

	function automatic logic [15:0] pick_feature();
		logic [15:0] corner[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001};
		case ($urandom_range(5))
			0: return corner[$urandom_range(4)];
			1, 2: return 16'(int'($urandom_range(12288)) - 6144);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_weights();
		logic [CFG_DATA_W-1:0] w;
		for (int j = 0; j < 3; j++) begin
			case ($urandom_range(7))
				0: w[16*j +: 16] = 16'h0000;
				1: w[16*j +: 16] = 16'h7FFF;
				2: w[16*j +: 16] = 16'h8000;
				3, 4, 5: w[16*j +: 16] = 16'(int'($urandom_range(4096)) - 2048);
				default: w[16*j +: 16] = 16'($urandom);
			endcase
		end
		return w;
	endfunction

	// result side: checks each transaction and stalls in bursts
	initial begin
		int hold_left;
		int burst_left;
		bit pressure_done;
		hold_left = 0;
		burst_left = 0;
		pressure_done = 1'b0;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall)
				board.check_output(result);
			// one long hold-off so the sample queue fills and stalls the sender
			if (!pressure_done && board.results_seen >= 40) begin
				pressure_done = 1'b1;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (burst_left > 0) begin
				burst_left--;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(4) == 0) begin
				burst_left = $urandom_range(6);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	initial begin
		in_item_t s;
		logic [15:0] knees[9];
		logic [15:0] ends_a[5];
		logic [15:0] ends_b[5];
		int sent;
		int len;
		int wait_cnt;
		knees = '{16'h0000, 16'h0FFF, 16'h1000, 16'h25FF, 16'h2600,
			16'h4FFF, 16'h5000, 16'h7FFF, 16'h8000};
		ends_a = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000};
		ends_b = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h0000};
		board = new();
		calm = 1'b0;
		arst_n <= 1'b0;
		sample_valid <= 1'b0;
		sample <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_IDX_WA;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset weights are zero, so the sigmoid sits at one half
		s = '{feature_a: 16'h7FFF, feature_b: 16'h8000, label: 1'b1, last_sample: 1'b0};
		send_sample(s);
		s = '{feature_a: 16'h8000, feature_b: 16'h7FFF, label: 1'b0, last_sample: 1'b1};
		send_sample(s);
		settle();

		// unit weights put z equal to feature_a, walking across each segment knee
		load_weights(48'h0000_0000_1000, 48'h0000_0000_0000, 48'h0000_0000_1000);
		for (int k = 0; k < 9; k++) begin
			s = '{feature_a: knees[k], feature_b: pick_feature(), label: k[0],
				last_sample: (k == 8)};
			send_sample(s);
		end
		settle();
		// same walk on the negative side
		load_weights(48'h0000_0000_1000, 48'h0000_0000_0000, 48'h0000_0000_F000);
		for (int k = 0; k < 9; k++) begin
			s = '{feature_a: knees[k], feature_b: pick_feature(), label: ~k[0],
				last_sample: (k == 8)};
			send_sample(s);
		end
		settle();
		load_weights(48'h8000_7FFF_8000, 48'h7FFF_8000_7FFF, 48'h7FFF_8000_8000);
		for (int k = 0; k < 5; k++) begin
			s = '{feature_a: ends_a[k], feature_b: ends_b[k], label: k[1],
				last_sample: (k == 4)};
			send_sample(s);
		end
		settle();

		// random data sets under random weights
		sent = 0;
		while (sent < 1100) begin
			load_weights(pick_weights(), pick_weights(), pick_weights());
			for (int d = 0; d < 4; d++) begin
				if (sent == 0)
					len = ROWS_TB;
				else if ($urandom_range(9) == 0)
					len = $urandom_range(60, 200);
				else
					len = $urandom_range(1, 24);
				for (int k = 0; k < len; k++) begin
					s.feature_a = pick_feature();
					s.feature_b = pick_feature();
					s.label = 1'($urandom_range(1));
					s.last_sample = (k == len - 1) || ($urandom_range(30) == 0);
					send_sample(s);
					sent++;
				end
			end
			settle();
		end

		// calm tail: worst-case error on every sample pushes the mean past its clamp
		calm = 1'b1;
		load_weights(48'h0000_0000_7FFF, 48'h0000_0000_0000, 48'h0000_0000_8000);
		for (int k = 0; k < 300; k++) begin
			s = '{feature_a: 16'h7FFF, feature_b: pick_feature(), label: 1'b1,
				last_sample: (k == 299)};
			send_sample(s);
		end

		sample_valid <= 1'b0;
		wait_cnt = 0;
		while (board.outputs_due.size() != 0 && wait_cnt < 20000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (80) @(posedge clk);
		board.errors += board.outputs_due.size();
		if (board.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/mlpf_pkg.sv
rtl/mlpf_div.sv
rtl/mlpf_front.sv
rtl/mlpf_back.sv
rtl/mlp_2_3_1_fitness_top.sv
verif/tb_mlp_2_3_1_fitness_top.sv
